@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ctd_pkg.sv @@
// Shared constants, types and index permutation for the CLUT texel decoder.
package ctd_pkg;

  localparam int PALETTE_DEPTH_DEF = 1024;

  localparam int MODE_W     = 3;
  localparam int LAYOUT_W   = 3;
  localparam int ADDR_W     = 10;
  localparam int LIDX_W     = 10;
  localparam int WORD_W     = 32;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_DIRECT32  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IDX8_C32  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_IDX8_C24  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_IDX4_C32  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_IDX4_C16  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_IDX8_C16P = 3'd5;

  localparam logic [LAYOUT_W-1:0] LAYOUT_NONE = 3'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_W32  = 3'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_W64  = 3'd2;
  localparam logic [LAYOUT_W-1:0] LAYOUT_W128 = 3'd3;
  localparam logic [LAYOUT_W-1:0] LAYOUT_W256 = 3'd4;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUT_LAYOUT = 1'b1;

  typedef enum logic [1:0] {
    FMT_C32,
    FMT_C24,
    FMT_C1555
  } fmt_t;

  typedef struct packed {
    fmt_t fmt;
    logic direct;
    logic oor;
    logic last;
  } lookup_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgba_t;

  function automatic logic [LIDX_W-1:0] permute_index(input logic [7:0] ix,
                                                     input logic [LAYOUT_W-1:0] layout);
    logic [LIDX_W-1:0] res;
    unique case (layout)
      LAYOUT_W32, LAYOUT_W64: res = {2'b00, ix[7:5], ix[3], ix[4], ix[2:0]};
      LAYOUT_W128: res = {2'b00, ix[6], ix[5], ix[3], ix[7], ix[4], ix[2:0]};
      LAYOUT_W256: res = {1'b1, ix[7], ix[6], ix[5], ix[3], 1'b0, ix[4], ix[2:0]};
      default: res = {2'b00, ix};
    endcase
    return res;
  endfunction

endpackage

@@ rtl/core/ctd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ctd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/ctd_color.sv @@
// Color expansion of a palette entry or direct word to RGBA8888.
module ctd_color (
  input  ctd_pkg::lookup_t                info,
  input  logic [ctd_pkg::WORD_W-1:0]      ram_word,
  input  logic [ctd_pkg::WORD_W-1:0]      direct_word,
  output ctd_pkg::rgba_t                  pixel
);

  logic [ctd_pkg::WORD_W-1:0] w;

  always_comb begin
    if (info.direct) begin
      w = direct_word;
    end else if (info.oor) begin
      w = '0;
    end else begin
      w = ram_word;
    end
  end

  always_comb begin
    pixel = '0;
    unique case (info.fmt)
      ctd_pkg::FMT_C32: begin
        pixel.red   = w[7:0];
        pixel.green = w[15:8];
        pixel.blue  = w[23:16];
        pixel.alpha = w[31] ? 8'hFF : {w[30:24], 1'b0};
      end
      ctd_pkg::FMT_C24: begin
        pixel.red   = w[7:0];
        pixel.green = w[15:8];
        pixel.blue  = w[23:16];
        pixel.alpha = 8'hFF;
      end
      ctd_pkg::FMT_C1555: begin
        pixel.red   = {w[4:0], w[4:2]};
        pixel.green = {w[9:5], w[9:7]};
        pixel.blue  = {w[14:10], w[14:12]};
        pixel.alpha = w[15] ? 8'hFF : 8'h00;
      end
      default: pixel = '0;
    endcase
  end

endmodule

@@ rtl/core/clut_texel_decoder.sv @@
// Palette texel decoder top level: issue stage, palette RAM stage, color output stage.
//
// Takes one transaction per cycle unless a 4-bit index item or a stalled output holds the
// issue stage: palette writes and one-pixel decodes each pass through it once, while the
// 4-bit index modes hold it until both nibbles are issued (low first), so such an item
// gives two results. A result shows on out_tvalid once its item has passed the issue
// register, which loads at the accepting edge, then the palette RAM read register, then
// the output register. The palette is one RAM of PALETTE_DEPTH 32-bit entries with one
// write and one registered read port; it is not cleared after reset and entries must be
// written before they are looked up. Lookups at or beyond PALETTE_DEPTH read a zero word.
module clut_texel_decoder #(
  parameter int PALETTE_DEPTH = ctd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // clut_address[9:0], clut_data[41:10], pixel_data[73:42], zero pad[79:74]
  input  logic [ctd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // action
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic [ctd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ctd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ctd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [ctd_pkg::LIDX_W:0] DEPTH_V = (ctd_pkg::LIDX_W + 1)'(PALETTE_DEPTH);
  localparam logic [ctd_pkg::ADDR_W:0] WDEPTH_V = (ctd_pkg::ADDR_W + 1)'(PALETTE_DEPTH);

  logic [ctd_pkg::MODE_W-1:0]   mode_r;
  logic [ctd_pkg::LAYOUT_W-1:0] layout_r;

  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_phase_r, s1_phase_nxt;
  logic                         s1_act_r;
  logic [ctd_pkg::ADDR_W-1:0]   s1_addr_r;
  logic [ctd_pkg::WORD_W-1:0]   s1_cdata_r;
  logic [ctd_pkg::WORD_W-1:0]   s1_pdata_r;

  logic                         s2_valid_r, s2_valid_nxt;
  ctd_pkg::lookup_t             s2_info_r;
  logic [ctd_pkg::WORD_W-1:0]   s2_pdata_r;
  logic [ctd_pkg::WORD_W-1:0]   ram_q;

  logic                         out_valid_r, out_valid_nxt;
  ctd_pkg::rgba_t               out_pix_r;
  logic                         out_last_r;

  logic                         in_fire;
  logic                         is_idx4;
  logic                         split_first;
  logic                         rd_go;
  logic                         wr_go;
  logic                         wr_en;
  logic                         s1_done;
  logic                         s2_ready;
  logic                         s3_ready;
  logic [3:0]                   nib;
  logic [ctd_pkg::LIDX_W-1:0]   lidx;
  ctd_pkg::lookup_t             s1_info;
  ctd_pkg::rgba_t               pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ctd_pkg::MODE_DIRECT32;
      layout_r <= ctd_pkg::LAYOUT_NONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ctd_pkg::CFG_PIXEL_MODE:  mode_r   <= cfg_data;
        ctd_pkg::CFG_CLUT_LAYOUT: layout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s3_ready = !out_valid_r || out_tready;
  assign s2_ready = !s2_valid_r || s3_ready;

  assign is_idx4 = (mode_r == ctd_pkg::MODE_IDX4_C32) || (mode_r == ctd_pkg::MODE_IDX4_C16);
  assign split_first = (s1_act_r == ctd_pkg::ACT_DECODE) && is_idx4 && !s1_phase_r;
  assign rd_go = s1_valid_r && (s1_act_r == ctd_pkg::ACT_DECODE) && s2_ready;
  assign wr_go = s1_valid_r && (s1_act_r == ctd_pkg::ACT_WRITE);
  assign s1_done = wr_go || (rd_go && !split_first);
  assign in_tready = !s1_valid_r || s1_done;
  assign in_fire = in_tvalid && in_tready;
  assign wr_en = wr_go && ({1'b0, s1_addr_r} < WDEPTH_V);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_phase_nxt = s1_phase_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_phase_nxt = 1'b0;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end else if (rd_go && split_first) begin
      s1_phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_phase_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_phase_r <= s1_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_act_r   <= in_tuser;
      s1_addr_r  <= in_tdata[9:0];
      s1_cdata_r <= in_tdata[41:10];
      s1_pdata_r <= in_tdata[73:42];
    end
  end

  assign nib = s1_phase_r ? s1_pdata_r[7:4] : s1_pdata_r[3:0];

  always_comb begin
    s1_info.direct = 1'b0;
    s1_info.fmt    = ctd_pkg::FMT_C32;
    s1_info.last   = !split_first;
    lidx           = '0;
    unique case (mode_r)
      ctd_pkg::MODE_IDX8_C32: begin
        lidx = {2'b00, s1_pdata_r[7:0]};
      end
      ctd_pkg::MODE_IDX8_C24: begin
        lidx        = {2'b00, s1_pdata_r[7:0]};
        s1_info.fmt = ctd_pkg::FMT_C24;
      end
      ctd_pkg::MODE_IDX4_C32: begin
        lidx = {6'd0, nib};
      end
      ctd_pkg::MODE_IDX4_C16: begin
        lidx        = {6'd0, nib};
        s1_info.fmt = ctd_pkg::FMT_C1555;
      end
      ctd_pkg::MODE_IDX8_C16P: begin
        lidx        = ctd_pkg::permute_index(s1_pdata_r[7:0], layout_r);
        s1_info.fmt = ctd_pkg::FMT_C1555;
      end
      default: begin
        s1_info.direct = 1'b1;
      end
    endcase
    s1_info.oor = ({1'b0, lidx} >= DEPTH_V);
  end

  ctd_ram #(
    .WIDTH (ctd_pkg::WORD_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r[AW-1:0]),
    .wr_data (s1_cdata_r),
    .rd_en   (rd_go),
    .rd_addr (lidx[AW-1:0]),
    .rd_data (ram_q)
  );

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s2_ready) begin
      s2_valid_nxt = rd_go;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      s2_info_r  <= s1_info;
      s2_pdata_r <= s1_pdata_r;
    end
  end

  ctd_color u_color (
    .info        (s2_info_r),
    .ram_word    (ram_q),
    .direct_word (s2_pdata_r),
    .pixel       (pix)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s3_ready) begin
      out_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      out_pix_r  <= pix;
      out_last_r <= s2_info_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/core/ctd_checker.sv @@
// Port-level checker for the CLUT texel decoder, bound to the top level.
`include "assert_macros.svh"

module ctd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ctd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `ASSERT_CLK(a_pair_follow, clk, rst_n, out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast, "second nibble result missing")
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid && in_tready, "pipeline not empty after reset")

endmodule

bind clut_texel_decoder ctd_checker u_ctd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
